### rtl/rfs_pkg.sv
// Shared constants and types for the relay firing sequencer.
`default_nettype none
package rfs_pkg;

  localparam int OUTPUT_COUNT     = 16;
  localparam int IDX_W            = $clog2(OUTPUT_COUNT);
  localparam int OUTPUTS_PER_AREA = 8;
  localparam int AREA_SHIFT       = $clog2(OUTPUTS_PER_AREA);
  localparam int AREA_W           = (IDX_W > AREA_SHIFT) ? IDX_W - AREA_SHIFT : 1;
  localparam int SETTLE_MS        = 60;
  localparam int POLL_MAX_MS      = 80;
  localparam int AREA_GAP_MS      = 200;
  localparam int FIRE_HOLD_RESET  = 100;
  localparam int BLINK_ARMED      = 50;
  localparam int BLINK_DISARMED   = 500;
  localparam int BLINK_MAX        = 1023;
  localparam int TIMER_W          = 16;
  localparam int BLINK_W          = 10;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_CHECK = 2'd1,
    OP_FIRE  = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_ARMED     = 4'd1,
    ST_DISARMED  = 4'd2,
    ST_CHECKING  = 4'd3,
    ST_CHECK_OK  = 4'd4,
    ST_CHECK_ERR = 4'd5,
    ST_FIRING    = 4'd6,
    ST_FIRE_OK   = 4'd7,
    ST_BAD_INDEX = 4'd8,
    ST_NOT_ARMED = 4'd9
  } status_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_SETTLE = 5'b00010,
    PH_POLL   = 5'b00100,
    PH_GAP    = 5'b01000,
    PH_FIRE   = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    QS_IDLE      = 2'd0,
    QS_CONNECTED = 2'd1,
    QS_FIRED     = 2'd2,
    QS_ENABLED   = 2'd3
  } qstat_t;

endpackage
`default_nettype wire

### rtl/relay_firing_sequencer.sv
// Relay firing sequencer: per-tick job control, arming, status and heartbeat.
//
// Usage: send one input beat per millisecond tick on in_valid/in_ready. Each
// beat carries a command (none, check connections, fire), the output to fire,
// the master switch and return-current sense levels, and an output to query.
// Every input beat yields exactly one result beat on out_valid/out_ready,
// registered in the cycle after acceptance. A new beat is accepted every cycle
// while the result register is empty or being drained in the same cycle, so
// throughput is one beat per cycle. If the receiver stalls, the pending result
// holds and in_ready drops until it is taken; no beat is lost or duplicated.
// The fire hold time is written on cfg_valid/cfg_ready/cfg_data, always
// ready, and should only be written while the block is idle.
// Reset (rst, synchronous) clears all output flags, job state, arming and
// heartbeat, sets the hold time to 100 ms and empties the result register.
`default_nettype none
module relay_firing_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [7:0]  output_index,
  input  wire logic        master_switch_on,
  input  wire logic        connection_sense,
  input  wire logic [3:0]  query_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             master_relay_on,
  output logic [3:0]       relay_select,
  output logic             relay_on,
  output logic             armed,
  output logic [3:0]       general_status,
  output logic             busy_res,
  output logic [1:0]       query_status,
  output logic             sanity_led
);

  localparam int N  = rfs_pkg::OUTPUT_COUNT;
  localparam int IW = rfs_pkg::IDX_W;
  localparam int TW = rfs_pkg::TIMER_W;
  localparam int BW = rfs_pkg::BLINK_W;
  localparam int AW = rfs_pkg::AREA_W;

  logic [TW-1:0]    fire_hold_ms;
  logic             armed_flag, armed_flag_next;
  rfs_pkg::status_t status_code, status_code_next;
  logic [N-1:0]     conn_flags, conn_flags_next;
  logic [N-1:0]     fired_flags, fired_flags_next;
  logic [N-1:0]     en_flags, en_flags_next;
  rfs_pkg::phase_t  job_phase, job_phase_next;
  logic [TW-1:0]    phase_timer, phase_timer_next;
  logic [IW-1:0]    current_output, current_output_next;
  logic [AW-1:0]    last_area, last_area_next;
  logic [BW-1:0]    blink_timer, blink_timer_next;
  logic             blink_level, blink_level_next;
  rfs_pkg::qstat_t  qs_next;

  logic             accept;
  logic             go_next;
  logic             driving;
  logic [AW-1:0]    area;
  logic [TW-1:0]    tmr_inc;
  logic [BW-1:0]    period;
  rfs_pkg::op_t     op;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign op        = rfs_pkg::op_t'(operation);

  always_comb begin
    job_phase_next      = job_phase;
    phase_timer_next    = phase_timer;
    current_output_next = current_output;
    last_area_next      = last_area;
    status_code_next    = status_code;
    armed_flag_next     = armed_flag;
    conn_flags_next     = conn_flags;
    fired_flags_next    = fired_flags;
    en_flags_next       = en_flags;
    blink_timer_next    = blink_timer;
    blink_level_next    = blink_level;
    go_next             = 1'b0;
    area                = AW'(current_output >> rfs_pkg::AREA_SHIFT);
    tmr_inc             = phase_timer + TW'(1);

    // job advance, sampling this tick's sense
    unique case (job_phase)
      rfs_pkg::PH_IDLE: begin
      end
      rfs_pkg::PH_SETTLE: begin
        phase_timer_next = tmr_inc;
        if (tmr_inc >= TW'(rfs_pkg::SETTLE_MS)) begin
          job_phase_next   = rfs_pkg::PH_POLL;
          phase_timer_next = '0;
        end
      end
      rfs_pkg::PH_POLL: begin
        conn_flags_next[current_output] = connection_sense;
        phase_timer_next = tmr_inc;
        if (connection_sense || tmr_inc >= TW'(rfs_pkg::POLL_MAX_MS)) begin
          if (area != last_area) begin
            last_area_next = area;
            if (rfs_pkg::AREA_GAP_MS > 0) begin
              job_phase_next   = rfs_pkg::PH_GAP;
              phase_timer_next = '0;
            end else begin
              go_next = 1'b1;
            end
          end else begin
            go_next = 1'b1;
          end
        end
      end
      rfs_pkg::PH_GAP: begin
        phase_timer_next = tmr_inc;
        if (tmr_inc >= TW'(rfs_pkg::AREA_GAP_MS)) go_next = 1'b1;
      end
      rfs_pkg::PH_FIRE: begin
        if (phase_timer != '1) phase_timer_next = tmr_inc;
        if (phase_timer_next >= fire_hold_ms) begin
          en_flags_next[current_output]    = 1'b0;
          fired_flags_next[current_output] = 1'b1;
          status_code_next = rfs_pkg::ST_FIRE_OK;
          job_phase_next   = rfs_pkg::PH_IDLE;
          phase_timer_next = '0;
        end
      end
      default: job_phase_next = rfs_pkg::PH_IDLE;
    endcase

    if (go_next) begin
      if (({1'b0, current_output} + (IW+1)'(1)) >= (IW+1)'(N)) begin
        job_phase_next   = rfs_pkg::PH_IDLE;
        phase_timer_next = '0;
        status_code_next = rfs_pkg::ST_CHECK_OK;
      end else begin
        current_output_next = current_output + IW'(1);
        conn_flags_next[current_output_next]  = 1'b0;
        fired_flags_next[current_output_next] = 1'b0;
        job_phase_next   = rfs_pkg::PH_SETTLE;
        phase_timer_next = '0;
      end
    end

    // command, ignored while a job runs
    if (job_phase_next == rfs_pkg::PH_IDLE) begin
      unique case (op)
        rfs_pkg::OP_CHECK: begin
          if (armed_flag) begin
            status_code_next = rfs_pkg::ST_CHECK_ERR;
          end else begin
            status_code_next    = rfs_pkg::ST_CHECKING;
            last_area_next      = '0;
            current_output_next = '0;
            conn_flags_next[0]  = 1'b0;
            fired_flags_next[0] = 1'b0;
            job_phase_next      = rfs_pkg::PH_SETTLE;
            phase_timer_next    = '0;
          end
        end
        rfs_pkg::OP_FIRE: begin
          if (output_index >= 8'(N)) begin
            status_code_next = rfs_pkg::ST_BAD_INDEX;
          end else if (!armed_flag) begin
            status_code_next = rfs_pkg::ST_NOT_ARMED;
          end else begin
            status_code_next    = rfs_pkg::ST_FIRING;
            current_output_next = output_index[IW-1:0];
            en_flags_next[output_index[IW-1:0]] = 1'b1;
            job_phase_next      = rfs_pkg::PH_FIRE;
            phase_timer_next    = '0;
          end
        end
        rfs_pkg::OP_NONE, rfs_pkg::OP_RSVD: begin
        end
      endcase
    end

    // arming follows the master switch
    if (!armed_flag && master_switch_on) begin
      armed_flag_next  = 1'b1;
      status_code_next = rfs_pkg::ST_ARMED;
    end else if (armed_flag && !master_switch_on) begin
      armed_flag_next  = 1'b0;
      status_code_next = rfs_pkg::ST_DISARMED;
    end

    // heartbeat
    period = armed_flag_next ? BW'(rfs_pkg::BLINK_ARMED) : BW'(rfs_pkg::BLINK_DISARMED);
    if (blink_timer != BW'(rfs_pkg::BLINK_MAX)) blink_timer_next = blink_timer + BW'(1);
    if (blink_timer_next > period) begin
      blink_timer_next = '0;
      blink_level_next = !blink_level;
    end

    priority if (en_flags_next[query_index[IW-1:0]]) qs_next = rfs_pkg::QS_ENABLED;
    else if (fired_flags_next[query_index[IW-1:0]])   qs_next = rfs_pkg::QS_FIRED;
    else if (conn_flags_next[query_index[IW-1:0]])    qs_next = rfs_pkg::QS_CONNECTED;
    else                                              qs_next = rfs_pkg::QS_IDLE;

    driving = job_phase_next == rfs_pkg::PH_SETTLE || job_phase_next == rfs_pkg::PH_POLL ||
              job_phase_next == rfs_pkg::PH_FIRE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fire_hold_ms   <= TW'(rfs_pkg::FIRE_HOLD_RESET);
      armed_flag     <= 1'b0;
      status_code    <= rfs_pkg::ST_IDLE;
      conn_flags     <= '0;
      fired_flags    <= '0;
      en_flags       <= '0;
      job_phase      <= rfs_pkg::PH_IDLE;
      phase_timer    <= '0;
      current_output <= '0;
      last_area      <= '0;
      blink_timer    <= '0;
      blink_level    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) fire_hold_ms <= cfg_data;
      if (accept) begin
        armed_flag     <= armed_flag_next;
        status_code    <= status_code_next;
        conn_flags     <= conn_flags_next;
        fired_flags    <= fired_flags_next;
        en_flags       <= en_flags_next;
        job_phase      <= job_phase_next;
        phase_timer    <= phase_timer_next;
        current_output <= current_output_next;
        last_area      <= last_area_next;
        blink_timer    <= blink_timer_next;
        blink_level    <= blink_level_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      master_relay_on <= job_phase_next == rfs_pkg::PH_FIRE;
      relay_select    <= driving ? 4'(current_output_next) : 4'd0;
      relay_on        <= driving;
      armed           <= armed_flag_next;
      general_status  <= status_code_next;
      busy_res        <= job_phase_next != rfs_pkg::PH_IDLE;
      query_status    <= qs_next;
      sanity_led      <= blink_level_next;
    end
  end

endmodule
`default_nettype wire
